// ===== sv/dotted_version_number_parser_defines.svh =====
// Assertion macros shared by the dotted version number parser checks.
// Depends on nothing; included by the checker file.
`ifndef DOTTED_VERSION_NUMBER_PARSER_DEFINES_SVH
`define DOTTED_VERSION_NUMBER_PARSER_DEFINES_SVH

// Same-cycle implication, switched off while reset is low
`define DVNP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dvnp: same-cycle check failed");

// Next-cycle implication, switched off while reset is low
`define DVNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dvnp: next-cycle check failed");

`endif

// ===== sv/dvnp_pkg.sv =====
// Shared widths and character codes for the dotted version number parser.
// No dependencies.
package dvnp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned DIGIT_W = 4;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_DOT  = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;

  // Largest value that may still take another digit: (2^32 - 1) / 10
  localparam logic [NUM_W-1:0]   ACC_LIMIT   = 32'd429496729;
  // Largest digit allowed on top of ACC_LIMIT
  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = 4'd5;

endpackage

// ===== sv/dvnp_stream_if.sv =====
// Valid/ready channels of the dotted version number parser: text in, result out.
// Depends on dvnp_pkg.
interface dvnp_text_if;
  logic                         valid;
  logic                         ready;
  logic [dvnp_pkg::BYTE_W-1:0]  text_byte;
  logic                         end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface dvnp_result_if;
  logic                         valid;
  logic                         ready;
  logic                         version_found;
  logic [dvnp_pkg::NUM_W-1:0]   major_number;
  logic [dvnp_pkg::NUM_W-1:0]   minor_number;
  logic [dvnp_pkg::NUM_W-1:0]   patch_number;

  modport source (output valid, version_found, major_number, minor_number, patch_number,
                  input ready);
  modport sink   (input valid, version_found, major_number, minor_number, patch_number,
                  output ready);
endinterface

// ===== sv/dotted_version_number_parser.sv =====
// Dotted version number parser: finds major.minor[.patch] on the first line of a text.
// Depends on dvnp_pkg and the channels in dvnp_stream_if.
//
// Usage
//   text_i carries one text byte per beat; end_of_text marks the last byte of a text.
//   result_o carries exactly one beat per text: version_found and the three numbers,
//   all zero when no well-formed version sits on the first line.
//   Only bytes up to the first CR or LF are parsed; the rest are taken and dropped.
// Timing
//   One byte is taken every cycle while no final byte waits for the result register.
//   A byte is held in the input register and folded into the parse state by a single
//   multiply-by-ten accumulate; a final byte then loads the result register.
// Reset
//   rst_ni low clears the parse state, the input register valid and the result valid.
//   After each final byte the parse state returns to its reset value for the next text.
// Stall
//   While a result waits on result_o, bytes that are not final keep flowing.
//   A final byte waits in the input register until the result register is free,
//   and text_i.ready drops only then.
module dotted_version_number_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dvnp_text_if.sink            text_i,
  dvnp_result_if.source        result_o
);

  typedef enum logic [2:0] {
    PH_SCAN,
    PH_MAJOR,
    PH_MINOR_FIRST,
    PH_MINOR,
    PH_PATCH_FIRST,
    PH_PATCH,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_DIGIT,
    CLS_DOT
  } class_e;

  // Input register
  logic                           in_valid_q;
  logic [dvnp_pkg::BYTE_W-1:0]    byte_q;
  logic                           eot_q;

  // Parse state
  phase_e                         phase_q, phase_d;
  class_e                         class_q, class_d;
  logic [dvnp_pkg::NUM_W-1:0]     acc_q, acc_d;
  logic                           ovf_q, ovf_d;
  logic [dvnp_pkg::NUM_W-1:0]     major_q, major_d;
  logic [dvnp_pkg::NUM_W-1:0]     minor_q, minor_d;
  logic                           ok_q, ok_d;

  // Result register
  logic                           out_valid_q;
  logic                           found_q;
  logic [dvnp_pkg::NUM_W-1:0]     res_major_q, res_minor_q, res_patch_q;

  // Byte decode and accumulate step
  logic                           is_digit, is_dot, is_eol;
  logic [dvnp_pkg::DIGIT_W-1:0]   digit;
  logic [dvnp_pkg::BYTE_W-1:0]    digit_byte;
  logic [dvnp_pkg::NUM_W+3:0]     acc_x10;
  logic [dvnp_pkg::NUM_W-1:0]     acc_step;
  logic                           digit_fits;

  logic                           out_free, fire;

  // Handshake: the parse stage moves unless a final byte meets a full result register
  assign out_free     = !out_valid_q || result_o.ready;
  assign fire         = in_valid_q && (!eot_q || out_free);
  assign text_i.ready = !in_valid_q || fire;

  // Classify the held byte
  assign is_digit   = (byte_q >= dvnp_pkg::CHAR_ZERO) && (byte_q <= dvnp_pkg::CHAR_NINE);
  assign is_dot     = (byte_q == dvnp_pkg::CHAR_DOT);
  assign is_eol     = (byte_q == dvnp_pkg::CHAR_CR) || (byte_q == dvnp_pkg::CHAR_LF);
  assign digit_byte = byte_q - dvnp_pkg::CHAR_ZERO;
  assign digit      = is_digit ? digit_byte[dvnp_pkg::DIGIT_W-1:0] : '0;

  // acc * 10 + digit, with the 32-bit range check ahead of it
  assign acc_x10    = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
  assign acc_step   = acc_x10[dvnp_pkg::NUM_W-1:0] + dvnp_pkg::NUM_W'(digit);
  assign digit_fits = !((acc_q > dvnp_pkg::ACC_LIMIT) ||
                        ((acc_q == dvnp_pkg::ACC_LIMIT) && (digit > dvnp_pkg::DIGIT_LIMIT)));

  // Next parse state for the held byte
  always_comb begin
    phase_d = phase_q;
    class_d = class_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    major_d = major_q;
    minor_d = minor_q;
    ok_d    = ok_q;

    if (phase_q != PH_DONE) begin
      if (!is_eol) begin
        case (phase_q)
          PH_SCAN: begin
            if (is_digit && (class_q == CLS_OTHER)) begin
              acc_d   = dvnp_pkg::NUM_W'(digit);
              ovf_d   = 1'b0;
              phase_d = PH_MAJOR;
            end
          end
          PH_MAJOR: begin
            if (is_digit) begin
              if (!ovf_q) begin
                if (digit_fits) acc_d = acc_step;
                else            ovf_d = 1'b1;
              end
            end else if (is_dot && !ovf_q) begin
              major_d = acc_q;
              phase_d = PH_MINOR_FIRST;
            end else begin
              phase_d = PH_SCAN;
            end
          end
          PH_MINOR_FIRST, PH_PATCH_FIRST: begin
            if (is_digit) begin
              acc_d   = dvnp_pkg::NUM_W'(digit);
              ovf_d   = 1'b0;
              phase_d = (phase_q == PH_MINOR_FIRST) ? PH_MINOR : PH_PATCH;
            end else begin
              ok_d    = 1'b0;
              phase_d = PH_DONE;
            end
          end
          PH_MINOR: begin
            if (is_digit) begin
              if (!ovf_q) begin
                if (digit_fits) acc_d = acc_step;
                else            ovf_d = 1'b1;
              end
            end else if (ovf_q) begin
              ok_d    = 1'b0;
              phase_d = PH_DONE;
            end else begin
              minor_d = acc_q;
              if (is_dot) begin
                phase_d = PH_PATCH_FIRST;
              end else begin
                acc_d   = '0;
                ok_d    = 1'b1;
                phase_d = PH_DONE;
              end
            end
          end
          PH_PATCH: begin
            if (is_digit) begin
              if (!ovf_q) begin
                if (digit_fits) acc_d = acc_step;
                else            ovf_d = 1'b1;
              end
            end else begin
              ok_d    = !ovf_q;
              phase_d = PH_DONE;
            end
          end
          default: begin
          end
        endcase
        class_d = is_digit ? CLS_DIGIT : (is_dot ? CLS_DOT : CLS_OTHER);
      end

      // Close the line on CR, LF or the final byte
      if ((is_eol || eot_q) && (phase_d != PH_DONE)) begin
        case (phase_d)
          PH_MINOR: begin
            minor_d = acc_d;
            ok_d    = !ovf_d;
            acc_d   = '0;
          end
          PH_PATCH: ok_d = !ovf_d;
          default:  ok_d = 1'b0;
        endcase
        phase_d = PH_DONE;
      end
    end
  end

  // Input register: take a beat whenever the stage is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (text_i.ready) begin
      in_valid_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.valid && text_i.ready) begin
      byte_q <= text_i.text_byte;
      eot_q  <= text_i.end_of_text;
    end
  end

  // Parse state: advance on each byte, start over after a final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SCAN;
      class_q <= CLS_OTHER;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      major_q <= '0;
      minor_q <= '0;
      ok_q    <= 1'b0;
    end else if (fire) begin
      if (eot_q) begin
        phase_q <= PH_SCAN;
        class_q <= CLS_OTHER;
        acc_q   <= '0;
        ovf_q   <= 1'b0;
        major_q <= '0;
        minor_q <= '0;
        ok_q    <= 1'b0;
      end else begin
        phase_q <= phase_d;
        class_q <= class_d;
        acc_q   <= acc_d;
        ovf_q   <= ovf_d;
        major_q <= major_d;
        minor_q <= minor_d;
        ok_q    <= ok_d;
      end
    end
  end

  // Result register: load on a final byte, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && eot_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && eot_q) begin
      found_q     <= ok_d;
      res_major_q <= ok_d ? major_d : '0;
      res_minor_q <= ok_d ? minor_d : '0;
      res_patch_q <= ok_d ? acc_d   : '0;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.version_found = found_q;
  assign result_o.major_number  = res_major_q;
  assign result_o.minor_number  = res_minor_q;
  assign result_o.patch_number  = res_patch_q;

endmodule

// ===== sv/dvnp_checker.sv =====
// Port-level checks of the dotted version number parser, bound to its top level.
// Depends on dvnp_pkg and dotted_version_number_parser_defines.svh.
`include "dotted_version_number_parser_defines.svh"

module dvnp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_eot_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        found_i,
  input logic [dvnp_pkg::NUM_W-1:0]  major_i,
  input logic [dvnp_pkg::NUM_W-1:0]  minor_i,
  input logic [dvnp_pkg::NUM_W-1:0]  patch_i
);

  // A stalled result beat holds its contents
  `DVNP_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(found_i) && $stable(major_i) && $stable(minor_i) && $stable(patch_i))

  // A miss reports all numbers as zero
  `DVNP_ASSERT_IMPLY(a_miss_zero, clk_i, rst_ni, out_valid_i && !found_i, (major_i == '0) && (minor_i == '0) && (patch_i == '0))

  // A fresh result follows a final byte taken on the text channel
  `DVNP_ASSERT_IMPLY(a_result_from_eot, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i && in_eot_i, 2))

endmodule

bind dotted_version_number_parser dvnp_checker u_dvnp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (text_i.valid),
  .in_ready_i  (text_i.ready),
  .in_eot_i    (text_i.end_of_text),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .found_i     (result_o.version_found),
  .major_i     (result_o.major_number),
  .minor_i     (result_o.minor_number),
  .patch_i     (result_o.patch_number)
);
